@@ rtl/core/pcba_pkg.sv @@
// constants and codes for the per-cpu bump allocator
// no dependencies; imported by the top level
`default_nettype none

package pcba_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_LIMIT   = 2'd1;

    // result status codes
    localparam logic [1:0] ST_ALLOC    = 2'd0;
    localparam logic [1:0] ST_GROWN    = 2'd1;
    localparam logic [1:0] ST_NO_SPACE = 2'd2;

    // field and datapath widths
    localparam int CFG_W  = 33;
    localparam int CPU_W  = 4;
    localparam int LEN_W  = 36;
    localparam int ADDR_W = 64;
    localparam int UNIT_W = 40;
    localparam int USED_W = 38;
    localparam int REM_W  = 33;

    // each cpu owns a 32 GiB window
    localparam int                WINDOW_SHIFT = 35;
    localparam logic [UNIT_W-1:0] WINDOW_LEN   = 40'h08_0000_0000;
    localparam logic [LEN_W-1:0]  INIT_SEG_LEN = 36'h1_0000_0000;
    localparam logic [CFG_W-1:0]  GROW_RESET   = 33'h0_0200_0000;

    // remainder loop walks every bit of the 36-bit difference
    localparam logic [5:0] DIV_LAST = 6'd35;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0_0000_0000_0001,
        S_READ  = 13'b0_0000_0000_0010,
        S_ADD   = 13'b0_0000_0000_0100,
        S_CHK   = 13'b0_0000_0000_1000,
        S_ADR1  = 13'b0_0000_0001_0000,
        S_ADR2  = 13'b0_0000_0010_0000,
        S_GCMP  = 13'b0_0000_0100_0000,
        S_GSTEP = 13'b0_0000_1000_0000,
        S_MOD   = 13'b0_0001_0000_0000,
        S_FIN1  = 13'b0_0010_0000_0000,
        S_FIN2  = 13'b0_0100_0000_0000,
        S_DONE  = 13'b0_1000_0000_0000
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/pcba_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies; used by the allocator for per-cpu state
`default_nettype none

module pcba_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic                                   i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/per_cpu_bump_allocator.sv @@
// per-cpu bump allocator: sequencer around one shared 40-bit add/subtract unit
// depends on pcba_pkg and pcba_ram
`default_nettype none

// One request at a time. Without growth a request goes from acceptance to the result
// register through the accepting cycle, six passes through the shared adder (the
// first alongside the state read) and the result load; a cpu index that is out of
// range goes straight to the result load, and a window overflow ends after the
// window check. Growth doubles the segment while it is below grow_limit and, once
// it has reached grow_limit, runs a bit-serial remainder over all 36 bits of
// (used - segment) by grow_limit, then a final subtract and add.
// Per-cpu offset and segment length live in one ram; valid bits stand in for
// the reset values, so there is no clearing pass. Input stall is low only
// while the sequencer is idle; a finished result may wait in the output
// register while the next request is accepted.
module per_cpu_bump_allocator
    import pcba_pkg::*;
#(
    parameter int NUM_CPUS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [CPU_W-1:0]     i_cpu_index,
    input  wire logic [LEN_W-1:0]     i_request_length,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic      [ADDR_W-1:0]    o_address,
    output logic      [1:0]           o_status,
    output logic      [LEN_W-1:0]     o_segment_length,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int IW = (AW > CPU_W) ? AW : CPU_W;
    localparam int RAM_W = 2 * LEN_W;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_base, r_grow;
    logic [CPU_W-1:0]  r_cpu, n_cpu;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_off, n_off;
    logic [LEN_W-1:0]  r_seg, n_seg;
    logic [USED_W-1:0] r_used, n_used;
    logic [LEN_W-1:0]  r_div, n_div;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [5:0]        r_cnt, n_cnt;
    logic [UNIT_W-1:0] r_addr, n_addr;
    logic [1:0]        r_status, n_status;
    logic              r_grown, n_grown;

    logic              r_out_valid;
    logic [UNIT_W-1:0] r_out_addr;
    logic [1:0]        r_out_status;
    logic [LEN_W-1:0]  r_out_seg;

    logic [NUM_CPUS-1:0] r_vld;

    // shared add/subtract unit
    logic [UNIT_W-1:0] w_ua, w_ub, w_ures;
    logic              w_usub, w_uge;
    logic [UNIT_W:0]   w_usum;

    logic              w_accept, w_load;
    logic [IW-1:0]     w_in_ext, w_cur_ext;
    logic [AW-1:0]     w_in_addr, w_cur_addr;
    logic [RAM_W-1:0]  w_rd_data;
    logic [CFG_W-1:0]  w_step;
    logic [REM_W:0]    w_trial;

    assign o_in_stall  = !r_state[0];
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    assign w_in_ext   = IW'(i_cpu_index);
    assign w_in_addr  = w_in_ext[AW-1:0];
    assign w_cur_ext  = IW'(r_cpu);
    assign w_cur_addr = w_cur_ext[AW-1:0];

    // a zero limit behaves as one
    assign w_step  = (r_grow == '0) ? CFG_W'(1) : r_grow;
    assign w_trial = {r_rem, r_div[LEN_W-1]};

    assign w_usum = {1'b0, w_ua} + {1'b0, (w_usub ? ~w_ub : w_ub)} + (UNIT_W+1)'(w_usub);
    assign w_ures = w_usum[UNIT_W-1:0];
    assign w_uge  = w_usum[UNIT_W];

    pcba_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_CPUS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_load && (r_status != ST_NO_SPACE)),
        .i_wr_addr (w_cur_addr),
        .i_wr_data ({r_seg, r_used[LEN_W-1:0]}),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_in_addr),
        .o_rd_data (w_rd_data)
    );

    // operand selection for the shared unit
    always_comb begin
        w_ua   = '0;
        w_ub   = '0;
        w_usub = 1'b0;
        unique case (r_state)
            S_READ: begin
                w_ua = UNIT_W'(r_len);
                w_ub = UNIT_W'(7);
            end
            S_ADD: begin
                w_ua = UNIT_W'(r_off);
                w_ub = UNIT_W'(r_used);
            end
            S_CHK: begin
                w_ua   = WINDOW_LEN;
                w_ub   = UNIT_W'(r_used);
                w_usub = 1'b1;
            end
            S_ADR1: begin
                w_ua = UNIT_W'(r_base);
                w_ub = UNIT_W'(r_off);
            end
            S_ADR2: begin
                w_ua = r_addr;
                w_ub = UNIT_W'(r_cpu) << WINDOW_SHIFT;
            end
            S_GCMP: begin
                w_ua   = UNIT_W'(r_used);
                w_ub   = UNIT_W'(r_seg);
                w_usub = 1'b1;
            end
            S_GSTEP: begin
                w_ua   = UNIT_W'(r_seg);
                w_ub   = UNIT_W'(w_step);
                w_usub = 1'b1;
            end
            S_MOD: begin
                w_ua   = UNIT_W'(w_trial);
                w_ub   = UNIT_W'(w_step);
                w_usub = 1'b1;
            end
            S_FIN1: begin
                w_ua   = UNIT_W'(r_used);
                w_ub   = UNIT_W'(r_rem);
                w_usub = 1'b1;
            end
            S_FIN2: begin
                w_ua = UNIT_W'(r_seg);
                w_ub = UNIT_W'(w_step);
            end
            default: begin
                w_usub = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_cpu    = r_cpu;
        n_len    = r_len;
        n_off    = r_off;
        n_seg    = r_seg;
        n_used   = r_used;
        n_div    = r_div;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_addr   = r_addr;
        n_status = r_status;
        n_grown  = r_grown;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cpu   = i_cpu_index;
                    n_len   = i_request_length;
                    n_grown = 1'b0;
                    if (32'(i_cpu_index) >= NUM_CPUS) begin
                        n_status = ST_NO_SPACE;
                        n_addr   = '0;
                        n_seg    = '0;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                // entries never written read as their reset values
                if (r_vld[w_cur_addr]) begin
                    n_off = w_rd_data[LEN_W-1:0];
                    n_seg = w_rd_data[RAM_W-1:LEN_W];
                end else begin
                    n_off = '0;
                    n_seg = INIT_SEG_LEN;
                end
                n_used  = USED_W'(w_ures) & ~USED_W'(7);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_used  = USED_W'(w_ures);
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!w_uge) begin
                    n_status = ST_NO_SPACE;
                    n_addr   = '0;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_ADR1;
                end
            end
            S_ADR1: begin
                n_addr  = w_ures;
                n_state = S_ADR2;
            end
            S_ADR2: begin
                n_addr  = w_ures;
                n_state = S_GCMP;
            end
            S_GCMP: begin
                if (!w_uge) begin
                    // segment now exceeds the used length
                    n_status = r_grown ? ST_GROWN : ST_ALLOC;
                    n_state  = S_DONE;
                end else begin
                    n_div   = LEN_W'(w_ures);
                    n_grown = 1'b1;
                    n_state = S_GSTEP;
                end
            end
            S_GSTEP: begin
                if (!w_uge) begin
                    n_seg   = (r_seg == '0) ? LEN_W'(1) : (r_seg << 1);
                    n_state = S_GCMP;
                end else begin
                    n_rem   = '0;
                    n_cnt   = DIV_LAST;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                // restoring remainder, one bit of (used - seg) per cycle
                n_rem = w_uge ? w_ures[REM_W-1:0] : w_trial[REM_W-1:0];
                n_div = r_div << 1;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    n_state = S_FIN1;
                end
            end
            S_FIN1: begin
                n_seg   = LEN_W'(w_ures);
                n_state = S_FIN2;
            end
            S_FIN2: begin
                n_seg   = LEN_W'(w_ures);
                n_state = S_GCMP;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cpu    <= n_cpu;
        r_len    <= n_len;
        r_off    <= n_off;
        r_seg    <= n_seg;
        r_used   <= n_used;
        r_div    <= n_div;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_addr   <= n_addr;
        r_status <= n_status;
        r_grown  <= n_grown;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_load && (r_status != ST_NO_SPACE)) begin
            r_vld[w_cur_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_grow <= GROW_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BASE_ADDRESS: r_base <= i_cfg_data;
                CFG_GROW_LIMIT:   r_grow <= i_cfg_data;
                default:          r_base <= r_base;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out_addr   <= r_addr;
            r_out_status <= r_status;
            r_out_seg    <= r_seg;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_address        = ADDR_W'(r_out_addr);
    assign o_status         = r_out_status;
    assign o_segment_length = r_out_seg;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_ALLOC || o_status == ST_GROWN ||
                         o_status == ST_NO_SPACE))
        else $error("result carries an unknown status code");

    a_no_space_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_NO_SPACE) |-> (o_address == '0))
        else $error("out-of-space result with nonzero address");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_rem < w_step))
        else $error("partial remainder not below the growth step");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("request accepted while a request is in progress");

endmodule

`default_nettype wire
